// File: rtl/core/wsdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the WebSocket backend deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // Frame header codes
    localparam logic [3:0] OPC_CLOSE   = 4'h8;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;

    // Header byte totals: two fixed bytes, extension bytes, mask key bytes
    localparam logic [3:0] HDR_BASE    = 4'd2;
    localparam logic [3:0] HDR_EXT16   = 4'd4;
    localparam logic [3:0] HDR_EXT64   = 4'd10;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Backend header: length, client id, backend id, big-endian
    localparam logic [3:0] BHDR_BYTES  = 4'd12;

    localparam int unsigned LIMIT_W    = 21;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'h10000;

    typedef enum logic [2:0] {
        PHASE_OPCODE,
        PHASE_LENGTH,
        PHASE_EXT_LEN,
        PHASE_MASK_KEY,
        PHASE_BACKEND_HDR,
        PHASE_DATA,
        PHASE_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        EVT_MSG_START    = 3'd0,
        EVT_PAYLOAD      = 3'd1,
        EVT_CLOSE        = 3'd2,
        EVT_TOO_LARGE    = 3'd3,
        EVT_TOO_SHORT    = 3'd4,
        EVT_LEN_MISMATCH = 3'd5
    } event_t;

    typedef struct packed {
        event_t              event_res;
        logic [7:0]          payload_byte;
        logic [31:0]         client_ident;
        logic [31:0]         backend_ident;
        logic [LIMIT_W-1:0]  message_length;
        logic                last;
    } result_t;

endpackage

// File: rtl/core/websocket_backend_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_backend_deframer_unit
// WebSocket frame deframer: header parse, unmask, backend header check.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  cfg       in         cfg_wr_en          cfg_wr_data (max frame size)
//  s_        in         s_valid / s_ready  s_rx_byte
//  m_        out        m_valid / m_ready  event, byte, idents, length, last
//
//  One byte is accepted per cycle while s_ready is high; its result, if any,
//  is registered in the output stage. The parser updates its state per byte.
//  Reset is synchronous; no clearing pass is needed after it.
//  A stalled result is held in the output register, a second one in the skid
//  entry; s_ready drops only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module websocket_backend_deframer_unit import wsdf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_event_res,
    output logic [7:0]         m_payload_byte,
    output logic [31:0]        m_client_ident,
    output logic [31:0]        m_backend_ident,
    output logic [LIMIT_W-1:0] m_message_length,
    output logic               m_last
);

    logic    byte_valid;
    logic    res_push;
    result_t res;
    result_t m_res;

    assign byte_valid = s_valid && s_ready;

    wsdf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .rx_byte     (s_rx_byte),
        .res_push    (res_push),
        .res         (res)
    );

    wsdf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .push_res (res),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    // Unpack the result fields onto ports
    assign m_event_res      = m_res.event_res;
    assign m_payload_byte   = m_res.payload_byte;
    assign m_client_ident   = m_res.client_ident;
    assign m_backend_ident  = m_res.backend_ident;
    assign m_message_length = m_res.message_length;
    assign m_last           = m_res.last;

endmodule

// File: rtl/core/wsdf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_parser
// Per-byte frame header tracker, payload unmasking and backend header check.
// ----------------------------------------------------------------------------
module wsdf_parser import wsdf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               byte_valid,
    input  logic [7:0]         rx_byte,
    output logic               res_push,
    output result_t            res
);

    phase_t              phase_reg, phase_next;
    logic [3:0]          opcode_reg, opcode_next;
    logic                mask_reg, mask_next;
    logic [63:0]         len_reg, len_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [31:0]         key_reg, key_next;
    logic [1:0]          kidx_reg, kidx_next;
    logic [95:0]         shift_reg, shift_next;
    logic [3:0]          hdr_reg, hdr_next;
    logic [LIMIT_W-1:0]  limit_reg;

    logic [7:0]          key_byte;
    logic [7:0]          plain;
    logic                finish_len;
    logic                finish_hdr;
    logic                too_large;
    logic [LIMIT_W:0]    size_total;

    // Select the key byte for this payload position
    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign plain = mask_reg ? (rx_byte ^ key_byte) : rx_byte;

    // Next state and result for one byte
    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        shift_next  = shift_reg;
        hdr_next    = hdr_reg;
        finish_len  = 1'b0;
        finish_hdr  = 1'b0;
        too_large   = 1'b0;
        size_total  = '0;
        res_push    = 1'b0;
        res         = '0;

        if (byte_valid) begin
            case (phase_reg)
                PHASE_OPCODE: begin
                    opcode_next = rx_byte[3:0];
                    key_next    = '0;
                    hdr_next    = HDR_BASE;
                    phase_next  = PHASE_LENGTH;
                end
                PHASE_LENGTH: begin
                    mask_next = rx_byte[7];
                    cnt_next  = '0;
                    len_next  = '0;
                    if (rx_byte[6:0] == LEN7_EXT16) begin
                        hdr_next   = HDR_EXT16;
                        phase_next = PHASE_EXT_LEN;
                    end else if (rx_byte[6:0] == LEN7_EXT64) begin
                        hdr_next   = HDR_EXT64;
                        phase_next = PHASE_EXT_LEN;
                    end else begin
                        len_next   = {57'd0, rx_byte[6:0]};
                        finish_len = 1'b1;
                    end
                end
                PHASE_EXT_LEN: begin
                    len_next = {len_reg[55:0], rx_byte};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= hdr_reg - HDR_BASE) begin
                        finish_len = 1'b1;
                    end
                end
                PHASE_MASK_KEY: begin
                    key_next = {key_reg[23:0], rx_byte};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= KEY_BYTES) begin
                        finish_hdr = 1'b1;
                    end
                end
                PHASE_BACKEND_HDR: begin
                    shift_next = {shift_reg[87:0], plain};
                    len_next   = len_reg - 64'd1;
                    kidx_next  = kidx_reg + 2'd1;
                    cnt_next   = cnt_reg + 4'd1;
                    if (cnt_next == BHDR_BYTES) begin
                        res_push = 1'b1;
                        if ({32'd0, shift_next[95:64]} != len_next) begin
                            res.event_res = EVT_LEN_MISMATCH;
                            res.last      = 1'b1;
                            phase_next    = (len_next == '0) ? PHASE_OPCODE : PHASE_SKIP;
                        end else begin
                            res.event_res      = EVT_MSG_START;
                            res.client_ident   = shift_next[63:32];
                            res.backend_ident  = shift_next[31:0];
                            res.message_length = shift_next[64 +: LIMIT_W];
                            res.last           = (len_next == '0);
                            phase_next = (len_next == '0) ? PHASE_OPCODE : PHASE_DATA;
                        end
                    end
                end
                PHASE_DATA: begin
                    len_next          = len_reg - 64'd1;
                    kidx_next         = kidx_reg + 2'd1;
                    res_push          = 1'b1;
                    res.event_res     = EVT_PAYLOAD;
                    res.payload_byte  = plain;
                    res.last          = (len_next == '0);
                    if (len_next == '0) begin
                        phase_next = PHASE_OPCODE;
                    end
                end
                PHASE_SKIP: begin
                    len_next = len_reg - 64'd1;
                    if (len_next == '0) begin
                        phase_next = PHASE_OPCODE;
                    end
                end
                default: begin
                    phase_next = PHASE_OPCODE;
                end
            endcase

            // Length complete: fetch the mask key or close the header
            if (finish_len) begin
                cnt_next = '0;
                if (mask_next) begin
                    hdr_next   = hdr_next + KEY_BYTES;
                    phase_next = PHASE_MASK_KEY;
                end else begin
                    finish_hdr = 1'b1;
                end
            end

            // Header complete: check opcode, frame size and minimum payload
            if (finish_hdr) begin
                cnt_next   = '0;
                kidx_next  = '0;
                size_total = {1'b0, len_next[LIMIT_W-1:0]} + {18'd0, hdr_next};
                too_large  = (len_next[63:LIMIT_W] != '0) ||
                             (size_total > {1'b0, limit_reg});
                if (opcode_next == OPC_CLOSE) begin
                    res.event_res = EVT_CLOSE;
                    res_push      = 1'b1;
                end else if (too_large) begin
                    res.event_res = EVT_TOO_LARGE;
                    res_push      = 1'b1;
                end else if (len_next < {60'd0, BHDR_BYTES}) begin
                    res.event_res = EVT_TOO_SHORT;
                    res_push      = 1'b1;
                end else begin
                    phase_next = PHASE_BACKEND_HDR;
                end
                if (res_push) begin
                    res.last   = 1'b1;
                    phase_next = (len_next == '0) ? PHASE_OPCODE : PHASE_SKIP;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_OPCODE;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            key_reg    <= '0;
            kidx_reg   <= '0;
            hdr_reg    <= HDR_BASE;
            limit_reg  <= LIMIT_RESET;
        end else begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            hdr_reg    <= hdr_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Backend header shift line, fully refilled before every use
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

endmodule

// File: rtl/core/wsdf_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_out_stage
// Result register with a skid entry so input ready is a registered signal.
// ----------------------------------------------------------------------------
module wsdf_out_stage import wsdf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_res,
    output logic    in_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;

    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_res    = main_reg;

    // Advance the result register, park a transfer in the skid on a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (m_ready || !main_valid_reg) begin
            main_reg <= skid_valid_reg ? skid_reg : push_res;
        end else if (push) begin
            skid_reg <= push_res;
        end
    end

endmodule

// File: rtl/core/wsdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsdf_checker import wsdf_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [7:0]         s_rx_byte,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_event_res,
    input logic [7:0]         m_payload_byte,
    input logic [31:0]        m_client_ident,
    input logic [31:0]        m_backend_ident,
    input logic [LIMIT_W-1:0] m_message_length,
    input logic               m_last
);

    // Hold a waiting byte transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("waiting byte changed");

    // Hold a stalled result transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) &&
        $stable(m_payload_byte) && $stable(m_client_ident) &&
        $stable(m_backend_ident) && $stable(m_message_length) && $stable(m_last))
        else $error("stalled result changed");

    // Drop results after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Close every error event
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EVT_CLOSE || m_event_res == EVT_TOO_LARGE ||
        m_event_res == EVT_TOO_SHORT || m_event_res == EVT_LEN_MISMATCH) |-> m_last)
        else $error("error event without last");

    // Mark an empty message as last on its start event
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EVT_MSG_START |->
        (m_last == (m_message_length == '0)))
        else $error("message start last flag wrong");

endmodule

bind websocket_backend_deframer_unit wsdf_checker u_wsdf_checker (.*);

// File: dv/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte input, the result output and the size register write of
// the deframer. It runs its own frame parser on every accepted byte, queues
// the events it predicts, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module deframer_checker import wsdf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_event_res,
    input  logic [7:0]         m_payload_byte,
    input  logic [31:0]        m_client_ident,
    input  logic [31:0]        m_backend_ident,
    input  logic [LIMIT_W-1:0] m_message_length,
    input  logic               m_last,
    output int unsigned        mismatch_count,
    output int unsigned        pending_results,
    output int unsigned        results_checked
);

    // Parser state, mirrored at the block's widths
    phase_t             rx_phase;
    logic [3:0]         opcode;
    logic               masked;
    logic [63:0]        frame_len;
    logic [3:0]         field_cnt;
    logic [31:0]        mask_key;
    logic [63:0]        pay_pos;
    logic [95:0]        bhdr_shift;
    logic [3:0]         hdr_total;
    logic [LIMIT_W-1:0] frame_limit;

    // Events predicted but not yet seen on the result channel
    result_t expected_events[$];

    function automatic result_t make_event(event_t ev, logic [7:0] pb, logic [31:0] cid,
                                           logic [31:0] bid, logic [LIMIT_W-1:0] len,
                                           logic lst);
        result_t r;
        r.event_res      = ev;
        r.payload_byte   = pb;
        r.client_ident   = cid;
        r.backend_ident  = bid;
        r.message_length = len;
        r.last           = lst;
        return r;
    endfunction

    // Strip the mask: key byte selected by payload index mod 4, MSB first
    function automatic logic [7:0] unmask_byte(logic [7:0] b);
        logic [1:0] k;
        k = pay_pos[1:0];
        if (!masked) return b;
        return b ^ mask_key[8*(3-k) +: 8];
    endfunction

    // Skip what is left of the frame, or go straight to the next one
    function automatic void skip_rest();
        rx_phase = (pay_pos >= frame_len) ? PHASE_OPCODE : PHASE_SKIP;
    endfunction

    // Header complete: close beats too large, too large beats too short
    function automatic bit finish_header(output result_t r);
        logic [64:0] total;
        event_t      ev;
        total   = {1'b0, frame_len} + hdr_total;
        pay_pos = '0;
        r       = '0;
        if (opcode == OPC_CLOSE) begin
            ev = EVT_CLOSE;
        end else if (total > frame_limit) begin
            ev = EVT_TOO_LARGE;
        end else if (frame_len < BHDR_BYTES) begin
            ev = EVT_TOO_SHORT;
        end else begin
            rx_phase = PHASE_BACKEND_HDR;
            return 1'b0;
        end
        skip_rest();
        r = make_event(ev, 8'h00, '0, '0, '0, 1'b1);
        return 1'b1;
    endfunction

    // Length known: collect the mask key first if there is one
    function automatic bit finish_length(output result_t r);
        field_cnt = '0;
        r         = '0;
        if (masked) begin
            hdr_total = hdr_total + KEY_BYTES;
            rx_phase  = PHASE_MASK_KEY;
            return 1'b0;
        end
        return finish_header(r);
    endfunction

    // Advance the parser by one byte; returns 1 when an event is produced
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [7:0]  u;
        logic [31:0] blen;
        r = '0;
        case (rx_phase)
            PHASE_OPCODE: begin
                opcode     = b[3:0];
                mask_key   = '0;
                bhdr_shift = '0;
                hdr_total  = HDR_BASE;
                rx_phase   = PHASE_LENGTH;
                return 1'b0;
            end
            PHASE_LENGTH: begin
                masked    = b[7];
                frame_len = '0;
                field_cnt = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    hdr_total = HDR_EXT16;
                    rx_phase  = PHASE_EXT_LEN;
                    return 1'b0;
                end
                if (b[6:0] == LEN7_EXT64) begin
                    hdr_total = HDR_EXT64;
                    rx_phase  = PHASE_EXT_LEN;
                    return 1'b0;
                end
                frame_len = {57'd0, b[6:0]};
                return finish_length(r);
            end
            PHASE_EXT_LEN: begin
                frame_len = {frame_len[55:0], b};
                field_cnt = field_cnt + 4'd1;
                if (field_cnt >= hdr_total - HDR_BASE) return finish_length(r);
                return 1'b0;
            end
            PHASE_MASK_KEY: begin
                mask_key  = {mask_key[23:0], b};
                field_cnt = field_cnt + 4'd1;
                if (field_cnt >= KEY_BYTES) return finish_header(r);
                return 1'b0;
            end
            PHASE_BACKEND_HDR: begin
                u          = unmask_byte(b);
                bhdr_shift = {bhdr_shift[87:0], u};
                pay_pos    = pay_pos + 64'd1;
                if (pay_pos < BHDR_BYTES) return 1'b0;
                blen = bhdr_shift[95:64];
                if ({32'd0, blen} != frame_len - BHDR_BYTES) begin
                    skip_rest();
                    r = make_event(EVT_LEN_MISMATCH, 8'h00, '0, '0, '0, 1'b1);
                    return 1'b1;
                end
                rx_phase = (blen == 0) ? PHASE_OPCODE : PHASE_DATA;
                r = make_event(EVT_MSG_START, 8'h00, bhdr_shift[63:32], bhdr_shift[31:0],
                               blen[LIMIT_W-1:0], blen == 0);
                return 1'b1;
            end
            PHASE_DATA: begin
                u       = unmask_byte(b);
                pay_pos = pay_pos + 64'd1;
                if (pay_pos >= frame_len) begin
                    rx_phase = PHASE_OPCODE;
                    r = make_event(EVT_PAYLOAD, u, '0, '0, '0, 1'b1);
                end else begin
                    r = make_event(EVT_PAYLOAD, u, '0, '0, '0, 1'b0);
                end
                return 1'b1;
            end
            PHASE_SKIP: begin
                pay_pos = pay_pos + 64'd1;
                if (pay_pos >= frame_len) rx_phase = PHASE_OPCODE;
                return 1'b0;
            end
            default: begin
                rx_phase = PHASE_OPCODE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Track the register, compare result transfers, predict from byte transfers
    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        if (!aresetn) begin
            rx_phase    = PHASE_OPCODE;
            opcode      = '0;
            masked      = 1'b0;
            frame_len   = '0;
            field_cnt   = '0;
            mask_key    = '0;
            pay_pos     = '0;
            bhdr_shift  = '0;
            hdr_total   = HDR_BASE;
            frame_limit = LIMIT_RESET;
            expected_events.delete();
        end else begin
            if (cfg_wr_en) frame_limit = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("result with no event pending: event_res %0d", m_event_res);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", want.event_res, m_event_res);
                    check_field("payload_byte", want.payload_byte, m_payload_byte);
                    check_field("client_ident", want.client_ident, m_client_ident);
                    check_field("backend_ident", want.backend_ident, m_backend_ident);
                    check_field("message_length", want.message_length, m_message_length);
                    check_field("last", want.last, m_last);
                    results_checked++;
                end
            end
            if (s_valid && s_ready) begin
                if (deframe_byte(s_rx_byte, got)) expected_events.push_back(got);
            end
        end
        pending_results = expected_events.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives WebSocket frames into the deframer: directed frames for each event
// and priority case, then random frames under several frame-size limits and
// idle patterns. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench import wsdf_pkg::*; ();

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    localparam int unsigned FULL_BODY        = 32'hFFFF_FFFF;
    localparam int unsigned RECV_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_BYTES     = 12;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_event_res;
    logic [7:0]         m_payload_byte;
    logic [31:0]        m_client_ident;
    logic [31:0]        m_backend_ident;
    logic [LIMIT_W-1:0] m_message_length;
    logic               m_last;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned results_checked;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_requests;
    int unsigned frames_sent;
    int unsigned bytes_sent;
    int unsigned limits_used;
    logic [LIMIT_W-1:0] limit_now;

    websocket_backend_deframer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_payload_byte   (m_payload_byte),
        .m_client_ident   (m_client_ident),
        .m_backend_ident  (m_backend_ident),
        .m_message_length (m_message_length),
        .m_last           (m_last)
    );

    deframer_checker result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_payload_byte   (m_payload_byte),
        .m_client_ident   (m_client_ident),
        .m_backend_ident  (m_backend_ident),
        .m_message_length (m_message_length),
        .m_last           (m_last),
        .mismatch_count   (mismatch_count),
        .pending_results  (pending_results),
        .results_checked  (results_checked)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin : receiver
        int unsigned hold_left;
        int unsigned hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = RECV_HOLD_CYCLES;
                m_ready     <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("[websocket_backend_deframer_unit] ERROR");
        $finish;
    end

    task automatic apply_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 65;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 65;
            end
            default: begin
                send_idle_pct  = 13;
                recv_stall_pct = 13;
            end
        endcase
    endtask

    // Offer one byte, with random idle cycles first; hold until transferred
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Stop sending and wait until every predicted event has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        limit_now = value;
        limits_used++;
    endtask

    // Build and send one frame; body_cap truncates the payload actually sent
    task automatic send_frame(input logic [3:0] opc, input logic use_mask,
                              input len_form_t form, input logic [63:0] plen,
                              input logic [31:0] blen, input logic [31:0] cid,
                              input logic [31:0] bid, input logic [31:0] key,
                              input int unsigned body_cap);
        logic [7:0]  b0;
        logic [6:0]  len7;
        logic [95:0] bhdr;
        logic [7:0]  plain;
        int unsigned body;
        b0      = 8'($urandom);
        b0[3:0] = opc;
        bhdr    = {blen, cid, bid};
        case (form)
            LEN_EXT16: len7 = LEN7_EXT16;
            LEN_EXT64: len7 = LEN7_EXT64;
            default:   len7 = plen[6:0];
        endcase
        send_byte(b0);
        send_byte({use_mask, len7});
        if (form == LEN_EXT16) begin
            send_byte(plen[15:8]);
            send_byte(plen[7:0]);
        end else if (form == LEN_EXT64) begin
            for (int i = 7; i >= 0; i--) send_byte(plen[8*i +: 8]);
        end
        if (use_mask) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
        end
        body = (plen > body_cap) ? body_cap : plen[31:0];
        for (int unsigned i = 0; i < body; i++) begin
            plain = (i < 12) ? bhdr[8*(11-i) +: 8] : 8'($urandom);
            if (use_mask) plain = plain ^ key[8*(3-i%4) +: 8];
            send_byte(plain);
        end
        frames_sent++;
    endtask

    // Mostly good messages; the rest errors, boundary sizes and noise frames
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned fpick;
        logic [3:0]  opc;
        logic [63:0] plen;
        logic [31:0] blen;
        len_form_t   form;
        pick = $urandom_range(99);
        opc  = 4'($urandom_range(15));
        if (opc == OPC_CLOSE) opc = 4'h1;
        blen = $urandom_range(16);
        if ($urandom_range(9) == 0) blen = $urandom_range(40, 17);
        plen = 64'(blen) + 64'd12;
        if (pick < 55) begin
            // good message, defaults stand
        end else if (pick < 65) begin
            plen = 64'($urandom_range(40, 12));
            blen = (plen[31:0] - 12) ^ (32'd1 << $urandom_range(31));
        end else if (pick < 75) begin
            plen = 64'($urandom_range(11));
        end else if (pick < 83) begin
            opc  = OPC_CLOSE;
            plen = 64'($urandom_range(30));
        end else if (pick < 91) begin
            // straddle the size limit where skipping the frame stays cheap
            if (limit_now <= 400) begin
                plen = 64'(limit_now) - 64'd3 + 64'($urandom_range(4));
            end
        end else begin
            opc  = 4'($urandom);
            plen = 64'($urandom_range(125));
            blen = $urandom;
        end
        fpick = $urandom_range(99);
        if (plen <= 125 && fpick < 60) form = LEN_SHORT;
        else if (plen <= 65535 && fpick < 85) form = LEN_EXT16;
        else form = LEN_EXT64;
        send_frame(opc, 1'($urandom_range(1)), form, plen, blen, $urandom, $urandom,
                   $urandom, FULL_BODY);
    endtask

    // Random frames with the idle pattern rotating every few frames
    task automatic send_random_frames();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            apply_idle_mode(idle_mode_t'((frames_sent / 3) % 4));
            send_random_frame();
        end
    endtask

    initial begin : stimulus
        int unsigned waited;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_rx_byte      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        frames_sent    = 0;
        bytes_sent     = 0;
        limits_used    = 0;
        limit_now      = LIMIT_RESET;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset limit: good messages in every length form, errors but too large
        apply_idle_mode(IDLE_NONE);
        send_frame(4'h1, 1'b0, LEN_SHORT, 12, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   $urandom, FULL_BODY);
        send_frame(4'h2, 1'b1, LEN_SHORT, 17, 5, 32'h0, 32'h0, 32'hFFFF_FFFF, FULL_BODY);
        hold_requests++;
        send_frame(4'h0, 1'b1, LEN_EXT16, 20, 8, $urandom, $urandom, 32'h0, FULL_BODY);
        send_frame(4'hF, 1'b0, LEN_EXT64, 15, 3, $urandom, $urandom, $urandom, FULL_BODY);
        apply_idle_mode(IDLE_BOTH);
        send_frame(OPC_CLOSE, 1'b0, LEN_SHORT, 0, 0, 0, 0, 0, FULL_BODY);
        send_frame(OPC_CLOSE, 1'b1, LEN_EXT16, 5, 0, 0, 0, $urandom, FULL_BODY);
        send_frame(4'h1, 1'b0, LEN_SHORT, 0, 0, 0, 0, 0, FULL_BODY);
        send_frame(4'h2, 1'b1, LEN_EXT64, 11, 0, $urandom, $urandom, $urandom, FULL_BODY);
        send_frame(4'h1, 1'b1, LEN_SHORT, 12, 1, $urandom, $urandom, $urandom, FULL_BODY);
        send_frame(4'h2, 1'b0, LEN_SHORT, 13, 32'h8000_0001, $urandom, $urandom, 0,
                   FULL_BODY);
        send_random_frames();

        // Smallest limit: only a bare 14-byte frame fits; error priorities
        write_limit(21'd14);
        apply_idle_mode(IDLE_SENDER);
        send_frame(4'h1, 1'b0, LEN_SHORT, 12, 0, $urandom, $urandom, 0, FULL_BODY);
        send_frame(4'h1, 1'b0, LEN_EXT16, 12, 0, $urandom, $urandom, 0, FULL_BODY);
        send_frame(4'h1, 1'b1, LEN_SHORT, 11, 0, 0, 0, $urandom, FULL_BODY);
        send_frame(OPC_CLOSE, 1'b0, LEN_SHORT, 20, 8, 0, 0, 0, FULL_BODY);
        send_random_frames();

        // Frame size exactly at and one past the limit
        write_limit(21'd20);
        apply_idle_mode(IDLE_RECEIVER);
        send_frame(4'h1, 1'b0, LEN_EXT16, 16, 4, $urandom, $urandom, 0, FULL_BODY);
        send_frame(4'h1, 1'b0, LEN_EXT16, 17, 5, $urandom, $urandom, 0, FULL_BODY);
        send_frame(4'h2, 1'b1, LEN_SHORT, 14, 2, $urandom, $urandom, $urandom, FULL_BODY);
        send_random_frames();

        write_limit(LIMIT_W'($urandom_range(100, 14)));
        send_random_frames();

        // Largest limit
        write_limit(21'h100000);
        apply_idle_mode(IDLE_NONE);
        send_random_frames();

        write_limit(LIMIT_W'($urandom_range(1048576, 14)));
        send_random_frames();

        // A length that would fit if cut to 32 bits must still be too large;
        // the parser then skips for the rest of the run
        write_limit(21'h100000);
        apply_idle_mode(IDLE_BOTH);
        send_frame(4'h1, 1'b0, LEN_EXT64, 64'h0000_0001_0000_0014, 8, $urandom, $urandom,
                   0, 16);

        s_valid <= 1'b0;
        waited = 0;
        while (pending_results != 0 && waited < 200000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (8) @(negedge aclk);
        if (pending_results != 0) $error("%0d predicted events never arrived", pending_results);

        $display("Sent %0d frames (%0d bytes) under %0d frame-size settings; %0d results checked",
                 frames_sent, bytes_sent, limits_used + 1, results_checked);
        $display("Covered all six events, idle and stall patterns, and a full-output hold-off");
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("[websocket_backend_deframer_unit] OK");
        end else begin
            $display("[websocket_backend_deframer_unit] ERROR");
        end
        $finish;
    end

endmodule
